// File: hw/rtl/kcfh_pkg.sv
`timescale 1ns / 1ps
// kcfh_pkg: constants, types and hash helpers shared by the
// keyed case-folded name hash core. no dependencies.

package kcfh_pkg;

  localparam logic [31:0] HASH_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] KEY_SEED   = 32'hA3B3_76C9;
  localparam logic [7:0]  FOLD_BIT   = 8'h20;
  localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
  localparam logic [31:0] MIX_MULT   = 32'h5bd1_e995;
  localparam logic [7:0]  END_CHAR   = 8'h00;

  // control from the input stage to the state and result stages
  typedef struct packed {
    logic fire;   // a character leaves the input register this cycle
    logic term;   // that character ends the name
  } step_t;

  // fold case, key with the low key byte, sign-extend
  function automatic logic [31:0] keyed_ext(input logic [7:0] ch, input logic [31:0] key);
    logic [7:0] b;
    begin
      b = (ch | FOLD_BIT) ^ key[7:0];
      keyed_ext = {{24{b[7]}}, b};
    end
  endfunction

  // murmur-style finalizer, all modulo 2^32
  function automatic logic [31:0] finalize(input logic [31:0] h);
    logic [31:0] h1;
    logic [31:0] m;
    begin
      h1 = h ^ (h >> 13);
      m = h1 * MIX_MULT;
      finalize = m ^ (m >> 15);
    end
  endfunction

endpackage

// File: hw/rtl/kcfh_absorb.sv
`timescale 1ns / 1ps
// kcfh_absorb: running hash and rolling key registers with the per-byte
// fnv-1a update and the finalized digest. uses kcfh_pkg.

module kcfh_absorb (
  input  logic                clk,
  input  logic                rst,
  input  kcfh_pkg::step_t     step,
  input  logic [7:0]          character,
  output logic [31:0]         digest
);

  logic [31:0] running_hash;
  logic [31:0] rolling_key;
  logic [31:0] ext;
  logic [31:0] running_hash_next;
  logic [31:0] rolling_key_next;

  always_comb begin
    ext = kcfh_pkg::keyed_ext(character, rolling_key);
    running_hash_next = (running_hash ^ ext) * kcfh_pkg::FNV_PRIME;
    rolling_key_next = {rolling_key[26:0] ^ ext[26:0], rolling_key[31:27] ^ ext[31:27]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= kcfh_pkg::HASH_BASIS;
      rolling_key <= kcfh_pkg::KEY_SEED;
    end else if (step.fire) begin
      if (step.term) begin
        running_hash <= kcfh_pkg::HASH_BASIS;
        rolling_key <= kcfh_pkg::KEY_SEED;
      end else begin
        running_hash <= running_hash_next;
        rolling_key <= rolling_key_next;
      end
    end
  end

  assign digest = kcfh_pkg::finalize(running_hash);

endmodule

// File: hw/rtl/kcfh_result.sv
`timescale 1ns / 1ps
// kcfh_result: result register holding one finalized hash until taken.
// uses kcfh_pkg.

module kcfh_result (
  input  logic            clk,
  input  logic            rst,
  input  kcfh_pkg::step_t step,
  input  logic [31:0]     digest,
  output logic            name_hash_valid,
  input  logic            name_hash_ready,
  output logic [31:0]     name_hash,
  output logic            free
);

  logic full;
  logic load;

  assign load = step.fire && step.term;
  assign free = !full || name_hash_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (name_hash_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      name_hash <= digest;
    end
  end

  assign name_hash_valid = full;

endmodule

// File: hw/rtl/keyed_case_folded_name_hash_core.sv
`timescale 1ns / 1ps
// keyed_case_folded_name_hash_core: one character per cycle, hash out on the end byte
// the end byte stalls in the input register until the result register has room,
//   then loads the result register that drives name_hash_valid; the character rate
//   is set by the hash/key feedback through the fnv prime multiply in kcfh_absorb
// reset: synchronous, empties input and result registers, reloads hash and key seeds

module keyed_case_folded_name_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        character_valid,
  output logic        character_ready,
  input  logic [7:0]  character,
  output logic        name_hash_valid,
  input  logic        name_hash_ready,
  output logic [31:0] name_hash
);

  // input register: one request waiting to be absorbed
  logic            in_full;
  logic [7:0]      in_char;
  logic            out_free;
  logic            advance;
  logic            is_end;
  logic [31:0]     digest;
  kcfh_pkg::step_t step;

  assign is_end = (in_char == kcfh_pkg::END_CHAR);

  // a plain character always moves on; an end byte needs room in the result register
  assign advance = in_full && (!is_end || out_free);
  assign character_ready = !in_full || advance;

  assign step.fire = advance;
  assign step.term = is_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (character_valid && character_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (character_valid && character_ready) begin
      in_char <= character;
    end
  end

  // running state: fold, key, xor, multiply, rotate the key
  kcfh_absorb u_absorb (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .character (in_char),
    .digest    (digest)
  );

  // finalized hash waits here so new characters keep flowing
  kcfh_result u_result (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .digest          (digest),
    .name_hash_valid (name_hash_valid),
    .name_hash_ready (name_hash_ready),
    .name_hash       (name_hash),
    .free            (out_free)
  );

endmodule
